// ----- design/caov_pkg.sv -----
// Shared types, register indexes, blend codes and helpers for the cursor overlay.
`timescale 1ns / 1ps

package caov_pkg;

  localparam int DEF_MAX_FRAME_DIM  = 8192;
  localparam int DEF_MAX_CURSOR_DIM = 256;

  localparam int POS_W   = 15;
  localparam int CDIM_W  = 9;
  localparam int FDIM_W  = 14;
  localparam int PIX_W   = 13;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H  = 3'd5;

  localparam logic [POS_W-1:0]  RST_CURSOR_X = 15'd0;
  localparam logic [POS_W-1:0]  RST_CURSOR_Y = 15'd0;
  localparam logic [CDIM_W-1:0] RST_CURSOR_W = 9'd32;
  localparam logic [CDIM_W-1:0] RST_CURSOR_H = 9'd32;
  localparam logic [FDIM_W-1:0] RST_FRAME_W  = 14'd1920;
  localparam logic [FDIM_W-1:0] RST_FRAME_H  = 14'd1080;

  localparam logic [BYTE_W-1:0] ALPHA_ZERO = 8'd0;
  localparam logic [BYTE_W-1:0] ALPHA_FULL = 8'd255;
  localparam logic [15:0]       ROUND_BIAS = 16'd127;

  localparam logic [1:0] MODE_PASS     = 2'd0;
  localparam logic [1:0] MODE_COPY     = 2'd1;
  localparam logic [1:0] MODE_STRAIGHT = 2'd2;
  localparam logic [1:0] MODE_PREMUL   = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0] cursor_x;
    logic signed [POS_W-1:0] cursor_y;
    logic [CDIM_W-1:0]       cursor_w;
    logic [CDIM_W-1:0]       cursor_h;
    logic [FDIM_W-1:0]       frame_w;
    logic [FDIM_W-1:0]       frame_h;
  } caov_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        mode;
    logic [BYTE_W-1:0] dst_alpha;
  } caov_ctrl_t;

  // x / 255 for x up to 65152, whose quotient never exceeds 255
  function automatic logic [BYTE_W-1:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

// ----- design/caov_window.sv -----
// Clipped cursor rectangle hit test for one pixel position.
`timescale 1ns / 1ps

module caov_window #(
  parameter int MAX_FRAME_DIM  = caov_pkg::DEF_MAX_FRAME_DIM,
  parameter int MAX_CURSOR_DIM = caov_pkg::DEF_MAX_CURSOR_DIM
) (
  input  caov_pkg::caov_cfg_t                cfg,
  input  logic [caov_pkg::PIX_W-1:0]         pix_x,
  input  logic [caov_pkg::PIX_W-1:0]         pix_y,
  output logic                               hit
);

  localparam int SPAN_W = caov_pkg::POS_W + 2;
  localparam logic [31:0] CUR_LIM = 32'(MAX_CURSOR_DIM);
  localparam logic [31:0] FRM_LIM = 32'(MAX_FRAME_DIM);

  logic [caov_pkg::CDIM_W-1:0] cw;
  logic [caov_pkg::CDIM_W-1:0] ch;
  logic [caov_pkg::FDIM_W-1:0] fw;
  logic [caov_pkg::FDIM_W-1:0] fh;
  logic                        hit_x;
  logic                        hit_y;

  function automatic logic in_span(input logic [caov_pkg::PIX_W-1:0] p,
                                   input logic [caov_pkg::POS_W-1:0] start,
                                   input logic [caov_pkg::CDIM_W-1:0] len,
                                   input logic [caov_pkg::FDIM_W-1:0] lim);
    logic signed [SPAN_W-1:0] sp;
    logic signed [SPAN_W-1:0] ss;
    logic signed [SPAN_W-1:0] se;
    logic signed [SPAN_W-1:0] sl;
    sp = $signed({{(SPAN_W-caov_pkg::PIX_W){1'b0}}, p});
    ss = $signed({{(SPAN_W-caov_pkg::POS_W){start[caov_pkg::POS_W-1]}}, start});
    se = ss + $signed({{(SPAN_W-caov_pkg::CDIM_W){1'b0}}, len});
    sl = $signed({{(SPAN_W-caov_pkg::FDIM_W){1'b0}}, lim});
    return (sp >= ss) && (sp < se) && (sp < sl);
  endfunction

  always_comb begin
    cw = ({23'd0, cfg.cursor_w} > CUR_LIM) ? CUR_LIM[caov_pkg::CDIM_W-1:0] : cfg.cursor_w;
    ch = ({23'd0, cfg.cursor_h} > CUR_LIM) ? CUR_LIM[caov_pkg::CDIM_W-1:0] : cfg.cursor_h;
    fw = ({18'd0, cfg.frame_w} > FRM_LIM) ? FRM_LIM[caov_pkg::FDIM_W-1:0] : cfg.frame_w;
    fh = ({18'd0, cfg.frame_h} > FRM_LIM) ? FRM_LIM[caov_pkg::FDIM_W-1:0] : cfg.frame_h;
    hit_x = in_span(pix_x, cfg.cursor_x, cw, fw);
    hit_y = in_span(pix_y, cfg.cursor_y, ch, fh);
    hit = hit_x && hit_y;
  end

endmodule

// ----- design/caov_lane.sv -----
// One colour channel: registered alpha products, then divide by 255 and select.
`timescale 1ns / 1ps

module caov_lane (
  input  logic                          clk,
  input  logic [caov_pkg::BYTE_W-1:0]   cur,
  input  logic [caov_pkg::BYTE_W-1:0]   dst,
  input  logic [caov_pkg::BYTE_W-1:0]   alpha,
  input  logic [1:0]                    mode,
  output logic [caov_pkg::BYTE_W-1:0]   result
);

  logic [15:0]                 cprod;
  logic [15:0]                 dprod;
  logic [caov_pkg::BYTE_W-1:0] cur_q;
  logic [caov_pkg::BYTE_W-1:0] dst_q;
  logic [caov_pkg::BYTE_W-1:0] straight;
  logic [caov_pkg::BYTE_W-1:0] dst_part;
  logic [caov_pkg::BYTE_W:0]   premul;

  always_ff @(posedge clk) begin
    cprod <= 16'(cur) * 16'(alpha);
    dprod <= 16'(dst) * 16'(caov_pkg::ALPHA_FULL - alpha);
    cur_q <= cur;
    dst_q <= dst;
  end

  always_comb begin
    straight = caov_pkg::div255(cprod + dprod + caov_pkg::ROUND_BIAS);
    dst_part = caov_pkg::div255(dprod + caov_pkg::ROUND_BIAS);
    premul   = {1'b0, cur_q} + {1'b0, dst_part};
    case (mode)
      caov_pkg::MODE_PASS:     result = dst_q;
      caov_pkg::MODE_COPY:     result = cur_q;
      caov_pkg::MODE_STRAIGHT: result = straight;
      caov_pkg::MODE_PREMUL:   result = premul[caov_pkg::BYTE_W] ? caov_pkg::ALPHA_FULL
                                                                 : premul[caov_pkg::BYTE_W-1:0];
      default:                 result = dst_q;
    endcase
  end

endmodule

// ----- design/cursor_alpha_overlay_core.sv -----
// Top level of the cursor alpha overlay: config registers, input stage, lanes, result stage.
`timescale 1ns / 1ps

// Composites one cursor pixel over one BGRA frame pixel per clock. A beat is taken at
// every rising edge with start high and busy low; busy is high only during reset. The
// result appears on the out ports with done high for exactly one cycle, in order; the
// receiver cannot stall, so it must take every result. A result passes the three
// register stages in turn: input, alpha products, result. Configuration writes are
// taken whenever cfg_ready is high and act on beats taken at the same edge or later.
module cursor_alpha_overlay_core #(
  parameter int MAX_FRAME_DIM  = caov_pkg::DEF_MAX_FRAME_DIM,
  parameter int MAX_CURSOR_DIM = caov_pkg::DEF_MAX_CURSOR_DIM
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [caov_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [caov_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic [caov_pkg::PIX_W-1:0]        pix_x,
  input  logic [caov_pkg::PIX_W-1:0]        pix_y,
  input  logic [caov_pkg::BYTE_W-1:0]       dst_blue,
  input  logic [caov_pkg::BYTE_W-1:0]       dst_green,
  input  logic [caov_pkg::BYTE_W-1:0]       dst_red,
  input  logic [caov_pkg::BYTE_W-1:0]       dst_alpha,
  input  logic [caov_pkg::BYTE_W-1:0]       cur_blue,
  input  logic [caov_pkg::BYTE_W-1:0]       cur_green,
  input  logic [caov_pkg::BYTE_W-1:0]       cur_red,
  input  logic [caov_pkg::BYTE_W-1:0]       cur_alpha,
  output logic                              done,
  output logic [caov_pkg::BYTE_W-1:0]       out_blue,
  output logic [caov_pkg::BYTE_W-1:0]       out_green,
  output logic [caov_pkg::BYTE_W-1:0]       out_red,
  output logic [caov_pkg::BYTE_W-1:0]       out_alpha,
  output logic                              covered
);

  caov_pkg::caov_cfg_t cfg;
  caov_pkg::caov_ctrl_t ctrl1;
  caov_pkg::caov_ctrl_t ctrl2;

  logic                        accept;
  logic                        valid1;
  logic [caov_pkg::PIX_W-1:0]  px1;
  logic [caov_pkg::PIX_W-1:0]  py1;
  logic [caov_pkg::BYTE_W-1:0] db1, dg1, dr1, da1;
  logic [caov_pkg::BYTE_W-1:0] cb1, cg1, cr1, ca1;
  logic                        hit;
  logic [1:0]                  mode_next;
  logic [caov_pkg::BYTE_W-1:0] lane_b, lane_g, lane_r;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cursor_x <= caov_pkg::RST_CURSOR_X;
      cfg.cursor_y <= caov_pkg::RST_CURSOR_Y;
      cfg.cursor_w <= caov_pkg::RST_CURSOR_W;
      cfg.cursor_h <= caov_pkg::RST_CURSOR_H;
      cfg.frame_w  <= caov_pkg::RST_FRAME_W;
      cfg.frame_h  <= caov_pkg::RST_FRAME_H;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        caov_pkg::REG_CURSOR_X: cfg.cursor_x <= cfg_data;
        caov_pkg::REG_CURSOR_Y: cfg.cursor_y <= cfg_data;
        caov_pkg::REG_CURSOR_W: cfg.cursor_w <= cfg_data[caov_pkg::CDIM_W-1:0];
        caov_pkg::REG_CURSOR_H: cfg.cursor_h <= cfg_data[caov_pkg::CDIM_W-1:0];
        caov_pkg::REG_FRAME_W:  cfg.frame_w  <= cfg_data[caov_pkg::FDIM_W-1:0];
        caov_pkg::REG_FRAME_H:  cfg.frame_h  <= cfg_data[caov_pkg::FDIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= accept;
    end
    px1 <= pix_x;
    py1 <= pix_y;
    db1 <= dst_blue;
    dg1 <= dst_green;
    dr1 <= dst_red;
    da1 <= dst_alpha;
    cb1 <= cur_blue;
    cg1 <= cur_green;
    cr1 <= cur_red;
    ca1 <= cur_alpha;
  end

  assign ctrl1 = '{valid: valid1, mode: mode_next, dst_alpha: da1};

  caov_window #(
    .MAX_FRAME_DIM  (MAX_FRAME_DIM),
    .MAX_CURSOR_DIM (MAX_CURSOR_DIM)
  ) u_window (
    .cfg   (cfg),
    .pix_x (px1),
    .pix_y (py1),
    .hit   (hit)
  );

  always_comb begin
    if (!hit || ca1 == caov_pkg::ALPHA_ZERO) begin
      mode_next = caov_pkg::MODE_PASS;
    end else if (ca1 == caov_pkg::ALPHA_FULL) begin
      mode_next = caov_pkg::MODE_COPY;
    end else if (cb1 > ca1 || cg1 > ca1 || cr1 > ca1) begin
      mode_next = caov_pkg::MODE_STRAIGHT;
    end else begin
      mode_next = caov_pkg::MODE_PREMUL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl2.valid <= 1'b0;
    end else begin
      ctrl2.valid <= ctrl1.valid;
    end
    ctrl2.mode      <= ctrl1.mode;
    ctrl2.dst_alpha <= ctrl1.dst_alpha;
  end

  caov_lane u_lane_b (
    .clk (clk), .cur (cb1), .dst (db1), .alpha (ca1), .mode (ctrl2.mode), .result (lane_b)
  );
  caov_lane u_lane_g (
    .clk (clk), .cur (cg1), .dst (dg1), .alpha (ca1), .mode (ctrl2.mode), .result (lane_g)
  );
  caov_lane u_lane_r (
    .clk (clk), .cur (cr1), .dst (dr1), .alpha (ca1), .mode (ctrl2.mode), .result (lane_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl2.valid;
    end
    out_blue  <= lane_b;
    out_green <= lane_g;
    out_red   <= lane_r;
    covered   <= (ctrl2.mode != caov_pkg::MODE_PASS);
    out_alpha <= (ctrl2.mode != caov_pkg::MODE_PASS) ? caov_pkg::ALPHA_FULL : ctrl2.dst_alpha;
  end

  a_done_follows_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a beat three cycles earlier");

  a_covered_opaque: assert property (@(posedge clk) disable iff (rst)
    (done && covered) |-> (out_alpha == caov_pkg::ALPHA_FULL))
    else $error("covered pixel without full alpha");

  a_pass_keeps_alpha: assert property (@(posedge clk) disable iff (rst)
    (done && !covered) |-> (out_alpha == $past(dst_alpha, 3)))
    else $error("passed pixel lost its frame alpha");

  a_transparent_passes: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cur_alpha, 3) == caov_pkg::ALPHA_ZERO) |-> !covered)
    else $error("transparent cursor pixel marked covered");

endmodule

// ----- tb/cursor_alpha_overlay_core_tb.sv -----
// Self-checking testbench for cursor_alpha_overlay_core: queued pixel beats, predicted blends.
`timescale 1ns / 1ps

module cursor_alpha_overlay_core_tb;
  import caov_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int PIX_MAX = 8191;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0]  pix_x;
    logic [PIX_W-1:0]  pix_y;
    logic [BYTE_W-1:0] dst_blue;
    logic [BYTE_W-1:0] dst_green;
    logic [BYTE_W-1:0] dst_red;
    logic [BYTE_W-1:0] dst_alpha;
    logic [BYTE_W-1:0] cur_blue;
    logic [BYTE_W-1:0] cur_green;
    logic [BYTE_W-1:0] cur_red;
    logic [BYTE_W-1:0] cur_alpha;
    logic [2:0]        gap;
  } pixel_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] alpha;
    logic              covered;
  } blended_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic [PIX_W-1:0] pix_x = '0;
  logic [PIX_W-1:0] pix_y = '0;
  logic [BYTE_W-1:0] dst_blue = '0;
  logic [BYTE_W-1:0] dst_green = '0;
  logic [BYTE_W-1:0] dst_red = '0;
  logic [BYTE_W-1:0] dst_alpha = '0;
  logic [BYTE_W-1:0] cur_blue = '0;
  logic [BYTE_W-1:0] cur_green = '0;
  logic [BYTE_W-1:0] cur_red = '0;
  logic [BYTE_W-1:0] cur_alpha = '0;

  wire logic cfg_ready;
  wire logic busy;
  wire logic done;
  wire logic [BYTE_W-1:0] out_blue;
  wire logic [BYTE_W-1:0] out_green;
  wire logic [BYTE_W-1:0] out_red;
  wire logic [BYTE_W-1:0] out_alpha;
  wire logic covered;

  logic signed [POS_W-1:0] cursor_x_now = RST_CURSOR_X;
  logic signed [POS_W-1:0] cursor_y_now = RST_CURSOR_Y;
  logic [CDIM_W-1:0] cursor_w_now = RST_CURSOR_W;
  logic [CDIM_W-1:0] cursor_h_now = RST_CURSOR_H;
  logic [FDIM_W-1:0] frame_w_now = RST_FRAME_W;
  logic [FDIM_W-1:0] frame_h_now = RST_FRAME_H;

  pixel_beat_t pending_pixels[$];
  blended_pixel_t blended_due[$];
  pixel_beat_t beat_now;
  blended_pixel_t oldest_due;
  int idle_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  cursor_alpha_overlay_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .pix_x(pix_x),
    .pix_y(pix_y),
    .dst_blue(dst_blue),
    .dst_green(dst_green),
    .dst_red(dst_red),
    .dst_alpha(dst_alpha),
    .cur_blue(cur_blue),
    .cur_green(cur_green),
    .cur_red(cur_red),
    .cur_alpha(cur_alpha),
    .done(done),
    .out_blue(out_blue),
    .out_green(out_green),
    .out_red(out_red),
    .out_alpha(out_alpha),
    .covered(covered)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int sat_dim(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic bit span_hit(int p, int first, int len, int limit);
    return (p >= first) && (p < first + len) && (p < limit);
  endfunction

  function automatic blended_pixel_t blend_pixel(pixel_beat_t b);
    blended_pixel_t r;
    logic [1:0] mode;
    int a, inv, k;
    int c[3];
    int d[3];
    int o[3];
    bit in_rect;
    bit hot;
    c[0] = b.cur_blue;
    c[1] = b.cur_green;
    c[2] = b.cur_red;
    d[0] = b.dst_blue;
    d[1] = b.dst_green;
    d[2] = b.dst_red;
    a = b.cur_alpha;
    inv = int'(ALPHA_FULL) - a;
    in_rect = span_hit(int'(b.pix_x), int'(cursor_x_now),
                       sat_dim(int'(cursor_w_now), DEF_MAX_CURSOR_DIM),
                       sat_dim(int'(frame_w_now), DEF_MAX_FRAME_DIM)) &&
              span_hit(int'(b.pix_y), int'(cursor_y_now),
                       sat_dim(int'(cursor_h_now), DEF_MAX_CURSOR_DIM),
                       sat_dim(int'(frame_h_now), DEF_MAX_FRAME_DIM));
    hot = (c[0] > a) || (c[1] > a) || (c[2] > a);
    if (!in_rect || b.cur_alpha == ALPHA_ZERO) begin
      mode = MODE_PASS;
    end else if (b.cur_alpha == ALPHA_FULL) begin
      mode = MODE_COPY;
    end else if (hot) begin
      mode = MODE_STRAIGHT;
    end else begin
      mode = MODE_PREMUL;
    end
    for (k = 0; k < 3; k++) begin
      case (mode)
        MODE_PASS: o[k] = d[k];
        MODE_COPY: o[k] = c[k];
        MODE_STRAIGHT: o[k] = (c[k] * a + d[k] * inv + int'(ROUND_BIAS)) / int'(ALPHA_FULL);
        default: begin
          o[k] = c[k] + (d[k] * inv + int'(ROUND_BIAS)) / int'(ALPHA_FULL);
          if (o[k] > int'(ALPHA_FULL)) o[k] = int'(ALPHA_FULL);
        end
      endcase
    end
    r.blue = o[0][7:0];
    r.green = o[1][7:0];
    r.red = o[2][7:0];
    r.alpha = (mode == MODE_PASS) ? b.dst_alpha : ALPHA_FULL;
    r.covered = (mode != MODE_PASS);
    return r;
  endfunction

  function automatic pixel_beat_t pixel(int x, int y, int db, int dg, int dr, int da,
                                        int cb, int cg, int cr, int ca);
    pixel_beat_t b;
    b.pix_x = x[PIX_W-1:0];
    b.pix_y = y[PIX_W-1:0];
    b.dst_blue = db[7:0];
    b.dst_green = dg[7:0];
    b.dst_red = dr[7:0];
    b.dst_alpha = da[7:0];
    b.cur_blue = cb[7:0];
    b.cur_green = cg[7:0];
    b.cur_red = cr[7:0];
    b.cur_alpha = ca[7:0];
    b.gap = 3'($urandom_range(0, 5));
    return b;
  endfunction

  function automatic pixel_beat_t random_pixel(int gap_cap);
    pixel_beat_t b;
    int x, y, pick, a;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      x = int'(cursor_x_now) - 2 +
          int'($urandom_range(0, sat_dim(int'(cursor_w_now), DEF_MAX_CURSOR_DIM) + 3));
      y = int'(cursor_y_now) - 2 +
          int'($urandom_range(0, sat_dim(int'(cursor_h_now), DEF_MAX_CURSOR_DIM) + 3));
    end else if (pick < 88) begin
      x = sat_dim(int'(frame_w_now), DEF_MAX_FRAME_DIM) - 2 + int'($urandom_range(0, 3));
      y = sat_dim(int'(frame_h_now), DEF_MAX_FRAME_DIM) - 2 + int'($urandom_range(0, 3));
    end else begin
      x = $urandom_range(0, PIX_MAX);
      y = $urandom_range(0, PIX_MAX);
    end
    if (x < 0 || x > PIX_MAX) x = $urandom_range(0, PIX_MAX);
    if (y < 0 || y > PIX_MAX) y = $urandom_range(0, PIX_MAX);
    pick = $urandom_range(0, 99);
    if (pick < 10) a = 0;
    else if (pick < 25) a = 255;
    else a = $urandom_range(1, 254);
    b = pixel(x, y, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, a);
    if ($urandom_range(0, 1) == 1) begin
      b.cur_blue = 8'($urandom_range(0, a));
      b.cur_green = 8'($urandom_range(0, a));
      b.cur_red = 8'($urandom_range(0, a));
    end
    b.gap = 3'($urandom_range(0, gap_cap));
    return b;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  task automatic check_byte(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || start || blended_due.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CURSOR_X: cursor_x_now = val;
      REG_CURSOR_Y: cursor_y_now = val;
      REG_CURSOR_W: cursor_w_now = val[CDIM_W-1:0];
      REG_CURSOR_H: cursor_h_now = val[CDIM_W-1:0];
      REG_FRAME_W: frame_w_now = val[FDIM_W-1:0];
      REG_FRAME_H: frame_h_now = val[FDIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic place_cursor(input int x, input int y, input int w, input int h,
                              input int fw, input int fh);
    wait_drained();
    cfg_write(REG_CURSOR_X, 15'(x));
    cfg_write(REG_CURSOR_Y, 15'(y));
    cfg_write(REG_CURSOR_W, 15'(w));
    cfg_write(REG_CURSOR_H, 15'(h));
    cfg_write(REG_FRAME_W, 15'(fw));
    cfg_write(REG_FRAME_H, 15'(fh));
    @(negedge clk);
  endtask

  task automatic queue_random(input int n, input int gap_cap);
    int k;
    for (k = 0; k < n; k++) pending_pixels.push_back(random_pixel(gap_cap));
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else if (!(start && busy)) begin
      if (start) blended_due.push_back(blend_pixel(beat_now));
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        beat_now = pending_pixels.pop_front();
        idle_left = beat_now.gap;
        pix_x <= beat_now.pix_x;
        pix_y <= beat_now.pix_y;
        dst_blue <= beat_now.dst_blue;
        dst_green <= beat_now.dst_green;
        dst_red <= beat_now.dst_red;
        dst_alpha <= beat_now.dst_alpha;
        cur_blue <= beat_now.cur_blue;
        cur_green <= beat_now.cur_green;
        cur_red <= beat_now.cur_red;
        cur_alpha <= beat_now.cur_alpha;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (blended_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat bgra %0d %0d %0d %0d covered %0b",
                                  out_blue, out_green, out_red, out_alpha, covered));
      end else begin
        oldest_due = blended_due.pop_front();
        check_byte("out_blue", out_blue, oldest_due.blue);
        check_byte("out_green", out_green, oldest_due.green);
        check_byte("out_red", out_red, oldest_due.red);
        check_byte("out_alpha", out_alpha, oldest_due.alpha);
        check_byte("covered", covered, oldest_due.covered);
      end
    end
  end

  initial begin
    int k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    pending_pixels.push_back(pixel(0, 0, 10, 20, 30, 40, 50, 60, 70, 0));
    pending_pixels.push_back(pixel(31, 31, 0, 0, 0, 0, 255, 255, 255, 255));
    pending_pixels.push_back(pixel(0, 0, 255, 255, 255, 255, 0, 0, 0, 255));
    pending_pixels.push_back(pixel(5, 5, 0, 0, 0, 0, 200, 200, 200, 128));
    pending_pixels.push_back(pixel(5, 6, 255, 255, 255, 255, 100, 128, 0, 128));
    pending_pixels.push_back(pixel(6, 5, 12, 34, 56, 78, 128, 128, 129, 128));
    pending_pixels.push_back(pixel(32, 0, 1, 2, 3, 4, 9, 9, 9, 255));
    pending_pixels.push_back(pixel(0, 32, 5, 6, 7, 8, 9, 9, 9, 255));
    pending_pixels.push_back(pixel(8191, 8191, 255, 255, 255, 255, 0, 0, 0, 255));
    pending_pixels.push_back(pixel(1, 1, 255, 255, 255, 255, 1, 1, 1, 1));
    pending_pixels.push_back(pixel(2, 2, 0, 0, 0, 0, 255, 0, 0, 1));
    pending_pixels.push_back(pixel(3, 3, 255, 255, 255, 255, 254, 254, 254, 254));
    pending_pixels.push_back(pixel(4, 4, 0, 255, 0, 0, 255, 255, 255, 254));
    pending_pixels.push_back(pixel(31, 0, 170, 85, 170, 85, 85, 170, 85, 255));
    queue_random(100, 5);

    place_cursor(100, 50, 64, 16, 1920, 1080);
    queue_random(100, 0);

    place_cursor(620, 470, 40, 40, 640, 480);
    pending_pixels.push_back(pixel(639, 470, 0, 0, 0, 0, 90, 80, 70, 200));
    pending_pixels.push_back(pixel(640, 470, 0, 0, 0, 0, 90, 80, 70, 200));
    pending_pixels.push_back(pixel(620, 479, 255, 0, 255, 0, 40, 30, 20, 60));
    pending_pixels.push_back(pixel(620, 480, 255, 0, 255, 0, 40, 30, 20, 60));
    queue_random(100, 5);

    place_cursor(-10, -20, 256, 256, 16383, 16383);
    queue_random(100, 5);

    place_cursor(0, 0, 300, 511, 8192, 8192);
    pending_pixels.push_back(pixel(255, 0, 0, 0, 0, 0, 1, 2, 3, 255));
    pending_pixels.push_back(pixel(256, 0, 0, 0, 0, 0, 1, 2, 3, 255));
    queue_random(80, 5);

    place_cursor(-16384, 16383, 511, 511, 8192, 8192);
    queue_random(40, 2);

    place_cursor(8000, 8000, 256, 256, 16383, 0);
    queue_random(40, 5);

    place_cursor(5, 5, 0, 10, 1920, 1080);
    queue_random(30, 5);

    place_cursor(0, 0, 1, 1, 1, 1);
    pending_pixels.push_back(pixel(0, 0, 7, 7, 7, 7, 250, 5, 128, 77));
    pending_pixels.push_back(pixel(1, 0, 7, 7, 7, 7, 250, 5, 128, 77));
    pending_pixels.push_back(pixel(0, 1, 7, 7, 7, 7, 250, 5, 128, 77));
    queue_random(40, 5);

    wait_drained();
    cfg_write(REG_SPARE_6, 15'($urandom));
    cfg_write(REG_SPARE_7, 15'($urandom));
    @(negedge clk);
    queue_random(40, 5);

    for (k = 0; k < 3; k++) begin
      if (k == 0) begin
        place_cursor($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        place_cursor($urandom_range(0, 2000), $urandom_range(0, 1200),
                     $urandom_range(1, 256), $urandom_range(1, 256),
                     $urandom_range(1, 8192), $urandom_range(1, 8192));
      end
      queue_random(40, 5);
      wait_drained();
      queue_random(40, 5);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/caov_pkg.sv
design/caov_window.sv
design/caov_lane.sv
design/cursor_alpha_overlay_core.sv
tb/cursor_alpha_overlay_core_tb.sv
